[rtl/cbgc_pkg.sv]
// Shared types and constants of the cache bin gc and fill policy block.
package cbgc_pkg;

    localparam int BIN_W   = 6;
    localparam int CNT_W   = 10;
    localparam int SHIFT_W = 4;
    localparam int CFG_W   = 7;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Request kinds
    localparam logic REQ_GC     = 1'b0;
    localparam logic REQ_REFILL = 1'b1;

    // Register indexes on the configuration port
    localparam logic REG_BINS_IN_USE     = 1'b0;
    localparam logic REG_SMALL_BIN_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] BINS_IN_USE_RST     = 7'd64;
    localparam logic [CFG_W-1:0] SMALL_BIN_COUNT_RST = 7'd36;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 4'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd15;
    localparam logic [SHIFT_W-1:0] SHIFT_RST = 4'd1;

    typedef struct packed {
        logic             req_type;
        logic [BIN_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_capacity;
        logic [CNT_W-1:0] min_level;
        logic [CNT_W-1:0] cached_count;
    } req_t;

    typedef struct packed {
        logic [BIN_W-1:0] handled_bin;
        logic             flush_requested;
        logic [CNT_W-1:0] keep_count;
        logic [CNT_W-1:0] fill_count;
        logic [BIN_W-1:0] gc_next;
    } res_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] fill_shift;
        logic               refilled_mark;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RST = '{fill_shift: SHIFT_RST, refilled_mark: 1'b0};

    typedef struct packed {
        logic [CFG_W-1:0] bins_in_use;
        logic [CFG_W-1:0] small_bin_count;
    } cfg_t;

endpackage

[rtl/cbgc_req_if.sv]
// Request channel interface: valid, ready and one request payload.
interface cbgc_req_if import cbgc_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/cbgc_res_if.sv]
// Result channel interface: valid, ready and one result payload.
interface cbgc_res_if import cbgc_pkg::*; ();
    logic valid;
    logic ready;
    res_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/cbgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cbgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/cbgc_apb_regs.sv]
// APB-style configuration registers: bins in use and small bin count.
module cbgc_apb_regs import cbgc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [CFG_W-1:0] bins_in_use_reg;
    logic [CFG_W-1:0] small_bin_count_reg;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Update the addressed register on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg     <= BINS_IN_USE_RST;
            small_bin_count_reg <= SMALL_BIN_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_BINS_IN_USE:     bins_in_use_reg     <= pwdata[CFG_W-1:0];
                REG_SMALL_BIN_COUNT: small_bin_count_reg <= pwdata[CFG_W-1:0];
                default:             ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (reg_sel)
            REG_BINS_IN_USE:     prdata = {{(32-CFG_W){1'b0}}, bins_in_use_reg};
            REG_SMALL_BIN_COUNT: prdata = {{(32-CFG_W){1'b0}}, small_bin_count_reg};
            default:             prdata = '0;
        endcase
    end

    assign cfg.bins_in_use     = bins_in_use_reg;
    assign cfg.small_bin_count = small_bin_count_reg;

endmodule

[rtl/cbgc_eval.sv]
// Policy evaluation: flush decision, fill amount and bin table entry update.
module cbgc_eval import cbgc_pkg::*; #(
    parameter int MAX_CAPACITY = 512
) (
    input  req_t             req,
    input  logic [BIN_W-1:0] bin,
    input  logic             in_range,
    input  logic [BIN_W-1:0] next_ptr,
    input  entry_t           entry,
    input  cfg_t             cfg,
    output res_t             res,
    output entry_t           entry_next
);

    localparam int CAP_LIMIT = (MAX_CAPACITY > CNT_MAX) ? CNT_MAX : MAX_CAPACITY;

    logic [CNT_W-1:0]   cap;
    logic [CNT_W-1:0]   drop;
    logic [SHIFT_W-1:0] shift_up;
    logic               small_bin;
    logic               can_grow;

    // Clamp capacity to the configured maximum
    assign cap = (32'(req.bin_capacity) > CAP_LIMIT) ? CNT_W'(CAP_LIMIT) : req.bin_capacity;

    assign drop      = req.min_level - (req.min_level >> 2);
    assign shift_up  = entry.fill_shift + SHIFT_MIN;
    assign small_bin = {1'b0, bin} < cfg.small_bin_count;
    assign can_grow  = small_bin && (entry.fill_shift < SHIFT_MAX) && ((cap >> shift_up) != '0);

    always_comb
    begin
        res.handled_bin     = bin;
        res.flush_requested = 1'b0;
        res.keep_count      = '0;
        res.fill_count      = '0;
        res.gc_next         = next_ptr;
        entry_next          = entry;

        if (req.req_type == REQ_GC)
        begin
            if (in_range && (req.min_level != '0))
            begin
                // Flush three quarters (rounded up) of the untouched objects
                res.flush_requested = 1'b1;
                res.keep_count      = (req.cached_count > drop) ?
                                      (req.cached_count - drop) : '0;
                if (can_grow)
                begin
                    entry_next.fill_shift = shift_up;
                end
            end
            else if (in_range && small_bin && entry.refilled_mark)
            begin
                // Bin ran dry after a refill: fetch more next time
                if (entry.fill_shift > SHIFT_MIN)
                begin
                    entry_next.fill_shift = entry.fill_shift - SHIFT_MIN;
                end
                entry_next.refilled_mark = 1'b0;
            end
        end
        else if (in_range)
        begin
            // Refill: capacity scaled down by the bin divisor
            res.fill_count           = cap >> entry.fill_shift;
            entry_next.refilled_mark = 1'b1;
        end
    end

endmodule

[rtl/cbgc_tick_ptr.sv]
// Round-robin gc pointer: advances on each accepted gc tick.
module cbgc_tick_ptr import cbgc_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  cfg_t             cfg,
    output logic [BIN_W-1:0] ptr,
    output logic [BIN_W-1:0] ptr_adv
);

    logic [BIN_W-1:0] ptr_reg;
    logic [BIN_W-1:0] ptr_next;
    logic [BIN_W:0]   inc;
    logic             wrap;

    assign inc     = {1'b0, ptr_reg} + 1'b1;
    assign wrap    = (inc >= cfg.bins_in_use) || (32'(inc) >= MAX_BINS);
    assign ptr_adv = wrap ? '0 : inc[BIN_W-1:0];

    assign ptr_next = advance ? ptr_adv : ptr_reg;

    // Hold the pointer between ticks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    assign ptr = ptr_reg;

endmodule

[rtl/cache_bin_gc_fill_policy.sv]
// An accepted request waits in the input stage registers and is evaluated
// into the result register once that is empty or its result is taken.
// Throughput: one request per cycle while results are taken; the bin table
// read happens on accept; the previous request's write is forwarded to evaluation.
// Reset: gc pointer zero, every bin reads shift one (divisor two), no refilled
// mark (per-bin valid flops, no clearing pass); registers return to 64 and 36.
module cache_bin_gc_fill_policy import cbgc_pkg::*; #(
    parameter int MAX_BINS     = 64,
    parameter int MAX_CAPACITY = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    cbgc_req_if.sink    req,
    cbgc_res_if.source  res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(MAX_BINS);

    cfg_t             cfg;
    logic             accept;
    logic             is_gc;
    logic [BIN_W-1:0] ptr;
    logic [BIN_W-1:0] ptr_adv;
    logic [BIN_W-1:0] bin_sel;
    logic [AW-1:0]    rd_addr;

    logic             s1_valid_reg;
    req_t             s1_req_reg;
    logic [BIN_W-1:0] s1_bin_reg;
    logic [BIN_W-1:0] s1_ptr_reg;
    logic             s1_in_range_reg;
    logic             s1_adv;
    logic [AW-1:0]    s1_addr;

    logic [MAX_BINS-1:0] valid_reg;
    logic                last_we_reg;
    logic [AW-1:0]       last_addr_reg;
    entry_t              last_entry_reg;

    logic [ENTRY_W-1:0] rd_data;
    entry_t             entry_cur;
    entry_t             entry_next;
    logic               wr_en;
    res_t               eval_res;

    logic res_valid_reg;
    res_t res_reg;

    cbgc_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Request intake
    assign s1_adv    = s1_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;
    assign is_gc     = (req.payload.req_type == REQ_GC);
    assign bin_sel   = is_gc ? ptr : req.payload.bin_index;
    assign rd_addr   = AW'(bin_sel);

    cbgc_tick_ptr #(
        .MAX_BINS (MAX_BINS)
    ) u_ptr (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept && is_gc),
        .cfg     (cfg),
        .ptr     (ptr),
        .ptr_adv (ptr_adv)
    );

    cbgc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr),
        .wdata (entry_next),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Input stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg      <= req.payload;
            s1_bin_reg      <= bin_sel;
            s1_ptr_reg      <= is_gc ? ptr_adv : ptr;
            s1_in_range_reg <= (32'(bin_sel) < MAX_BINS);
        end
    end

    // Pick the current table entry: forwarded write, stored entry or reset value
    assign s1_addr = AW'(s1_bin_reg);

    always_comb
    begin
        if (last_we_reg && (last_addr_reg == s1_addr))
        begin
            entry_cur = last_entry_reg;
        end
        else if (valid_reg[s1_addr])
        begin
            entry_cur = rd_data;
        end
        else
        begin
            entry_cur = ENTRY_RST;
        end
    end

    cbgc_eval #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_eval (
        .req        (s1_req_reg),
        .bin        (s1_bin_reg),
        .in_range   (s1_in_range_reg),
        .next_ptr   (s1_ptr_reg),
        .entry      (entry_cur),
        .cfg        (cfg),
        .res        (eval_res),
        .entry_next (entry_next)
    );

    assign wr_en = s1_adv && s1_in_range_reg;

    // Track written entries and the last write for forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            last_we_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg[s1_addr] <= 1'b1;
            last_we_reg        <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            last_addr_reg  <= s1_addr;
            last_entry_reg <= entry_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg <= eval_res;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_reg;

endmodule
